### rtl/rhp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the RTP header parser.
// No dependencies; used by every module of the block.
package rhp_pkg;

  localparam int unsigned MAX_DATAGRAM_BYTES_DEF = 65535;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [6:0] FIXED_HDR   = 7'd12;
  localparam logic [2:0] EXT_HDR     = 3'd4;
  localparam logic [1:0] RTP_VERSION = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_CSRC     = 3'd3,
    ST_EXT_HDR  = 3'd4,
    ST_EXT_DATA = 3'd5,
    ST_PADDING  = 3'd6
  } rhp_status_e;

  // One finished datagram as captured by the front end.
  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] source;
    logic [15:0] ext_words;
    logic [31:0] arrival;
    logic [7:0]  pad;
  } rhp_rec_t;

endpackage

### rtl/rhp_front.sv
`timescale 1ns / 1ps
// Front end: counts datagram bytes, captures header words and hands
// one record per datagram to the queue. Depends on rhp_pkg.
module rhp_front #(
  parameter int unsigned MAX_DATAGRAM_BYTES = rhp_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic [31:0]      arrival_time_i,
  input  logic             q_full_i,
  output logic             push_o,
  output rhp_pkg::rhp_rec_t rec_o
);

  logic [15:0] idx_q, idx_d;
  logic [7:0]  hdr0_q, hdr0_d, hdr1_q, hdr1_d;
  logic [15:0] seq_q, seq_d, ext_q, ext_d;
  logic [31:0] stamp_q, stamp_d, source_q, source_d, arrival_q, arrival_d;
  logic [15:0] ext_at;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ext_at     = 16'(rhp_pkg::FIXED_HDR) + {10'd0, hdr0_q[3:0], 2'b00};

  always_comb begin
    idx_d     = idx_q;
    hdr0_d    = hdr0_q;
    hdr1_d    = hdr1_q;
    seq_d     = seq_q;
    stamp_d   = stamp_q;
    source_d  = source_q;
    ext_d     = ext_q;
    arrival_d = arrival_q;
    if (accept) begin
      if (idx_q == 16'd0) arrival_d = arrival_time_i;
      if (idx_q < 16'(MAX_DATAGRAM_BYTES)) begin
        if (idx_q == 16'd0)       hdr0_d   = data_byte_i;
        else if (idx_q == 16'd1)  hdr1_d   = data_byte_i;
        else if (idx_q < 16'd4)   seq_d    = {seq_q[7:0], data_byte_i};
        else if (idx_q < 16'd8)   stamp_d  = {stamp_q[23:0], data_byte_i};
        else if (idx_q < 16'd12)  source_d = {source_q[23:0], data_byte_i};
        else if (hdr0_q[4] && (idx_q == ext_at + 16'd2 || idx_q == ext_at + 16'd3))
          ext_d = {ext_q[7:0], data_byte_i};
        idx_d = idx_q + 16'd1;
      end
    end
  end

  assign push_o = accept && last_byte_i;

  always_comb begin
    rec_o.len       = idx_d;
    rec_o.hdr0      = hdr0_d;
    rec_o.hdr1      = hdr1_d;
    rec_o.seq       = seq_d;
    rec_o.stamp     = stamp_d;
    rec_o.source    = source_d;
    rec_o.ext_words = ext_d;
    rec_o.arrival   = arrival_d;
    rec_o.pad       = data_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      hdr0_q    <= '0;
      hdr1_q    <= '0;
      seq_q     <= '0;
      stamp_q   <= '0;
      source_q  <= '0;
      ext_q     <= '0;
      arrival_q <= '0;
    end else begin
      hdr0_q    <= hdr0_d;
      hdr1_q    <= hdr1_d;
      seq_q     <= seq_d;
      stamp_q   <= stamp_d;
      source_q  <= source_d;
      arrival_q <= arrival_d;
      // start a new datagram after the flagged byte
      if (push_o) begin
        idx_q <= '0;
        ext_q <= '0;
      end else begin
        idx_q <= idx_d;
        ext_q <= ext_d;
      end
    end
  end

endmodule

### rtl/rhp_queue.sv
`timescale 1ns / 1ps
// Short record queue between front end and back end.
// Depends on rhp_pkg.
module rhp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rhp_pkg::rhp_rec_t rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rhp_pkg::rhp_rec_t rec_o
);

  localparam int unsigned PtrW = (rhp_pkg::QUEUE_DEPTH > 1) ? $clog2(rhp_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(rhp_pkg::QUEUE_DEPTH + 1);

  rhp_pkg::rhp_rec_t mem_q [rhp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(rhp_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(rhp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(rhp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

### rtl/rhp_back.sv
`timescale 1ns / 1ps
// Back end: checks one queued record, works out status, payload offset
// and size, and holds the descriptor in an output register. Uses rhp_pkg.
module rhp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  rhp_pkg::rhp_rec_t rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic              marker_o,
  output logic [6:0]        rtp_pt_o,
  output logic [15:0]       seq_num_o,
  output logic [31:0]       media_timestamp_o,
  output logic [31:0]       source_id_o,
  output logic [15:0]       payload_start_o,
  output logic [15:0]       payload_length_o,
  output logic [31:0]       arrival_time_out_o
);

  rhp_pkg::rhp_status_e st;
  logic [17:0] len, off, csrc, ext_bytes, pad, size;
  logic        ok;

  always_comb begin
    len       = {2'b00, rec_i.len};
    csrc      = {12'd0, rec_i.hdr0[3:0], 2'b00};
    ext_bytes = {rec_i.ext_words, 2'b00};
    pad       = {10'd0, rec_i.pad};
    off       = 18'(rhp_pkg::FIXED_HDR);
    st        = rhp_pkg::ST_OK;
    if (len < off) begin
      st = rhp_pkg::ST_SHORT;
    end else if (rec_i.hdr0[7:6] != rhp_pkg::RTP_VERSION) begin
      st = rhp_pkg::ST_VERSION;
    end else if (len - off < csrc) begin
      st = rhp_pkg::ST_CSRC;
    end else begin
      off = off + csrc;
      if (rec_i.hdr0[4]) begin
        if (len - off < 18'(rhp_pkg::EXT_HDR)) begin
          st = rhp_pkg::ST_EXT_HDR;
        end else begin
          off = off + 18'(rhp_pkg::EXT_HDR);
          if (len - off < ext_bytes) st = rhp_pkg::ST_EXT_DATA;
          else off = off + ext_bytes;
        end
      end
      if (st == rhp_pkg::ST_OK && rec_i.hdr0[5]) begin
        if (pad == '0 || pad > len - off) st = rhp_pkg::ST_PADDING;
      end
    end
    if (!rec_i.hdr0[5]) pad = '0;
    size = len - off - pad;
    ok   = (st == rhp_pkg::ST_OK);
  end

  assign pop_o = q_valid_i && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || out_ready_i) begin
      out_valid_o <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_o           <= st;
      marker_o           <= ok & rec_i.hdr1[7];
      rtp_pt_o           <= ok ? rec_i.hdr1[6:0] : '0;
      seq_num_o          <= ok ? rec_i.seq : '0;
      media_timestamp_o  <= ok ? rec_i.stamp : '0;
      source_id_o        <= ok ? rec_i.source : '0;
      payload_start_o    <= ok ? off[15:0] : '0;
      payload_length_o   <= ok ? size[15:0] : '0;
      arrival_time_out_o <= rec_i.arrival;
    end
  end

endmodule

### rtl/rtp_header_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the RTP header parser: front end, record queue, back end.
// Depends on rhp_pkg, rhp_front, rhp_queue and rhp_back.
//
//  channel   direction  handshake               payload
//  input     in         in_valid_i/in_ready_o   data_byte_i, last_byte_i, arrival_time_i
//  result    out        out_valid_o/out_ready_i status_o ... arrival_time_out_o
//
// One datagram byte is taken each cycle while the record queue has room;
// the front end only counts and captures, so bytes stream at full rate.
// After its flagged byte a descriptor is written into the record queue,
// then passes the back-end checks into the output register.
// Reset (rst_ni low) clears the byte counter, capture registers and queue.
// A stalled result side fills the two-entry queue; in_ready_o then drops
// until the back end frees an entry.
module rtp_header_parser_unit #(
  parameter int unsigned MAX_DATAGRAM_BYTES = rhp_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] arrival_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        marker_o,
  output logic [6:0]  rtp_pt_o,
  output logic [15:0] seq_num_o,
  output logic [31:0] media_timestamp_o,
  output logic [31:0] source_id_o,
  output logic [15:0] payload_start_o,
  output logic [15:0] payload_length_o,
  output logic [31:0] arrival_time_out_o
);

  // records of finished datagrams, front to back
  rhp_pkg::rhp_rec_t push_rec, head_rec;
  logic              push, q_full, q_valid, pop;

  // Count and capture bytes; push a record on each flagged byte.
  rhp_front #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .arrival_time_i(arrival_time_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  // Hold records so either side can stall on its own.
  rhp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rec_o  (head_rec)
  );

  // Check the header and register the descriptor for transfer.
  rhp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .rec_i             (head_rec),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .marker_o          (marker_o),
    .rtp_pt_o          (rtp_pt_o),
    .seq_num_o         (seq_num_o),
    .media_timestamp_o (media_timestamp_o),
    .source_id_o       (source_id_o),
    .payload_start_o   (payload_start_o),
    .payload_length_o  (payload_length_o),
    .arrival_time_out_o(arrival_time_out_o)
  );

endmodule

### rtl/rhp_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the RTP header parser, bound to the top level.
// Depends on rhp_pkg and rtp_header_parser_unit.
module rhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic        marker_o,
  input logic [6:0]  rtp_pt_o,
  input logic [15:0] seq_num_o,
  input logic [31:0] media_timestamp_o,
  input logic [31:0] source_id_o,
  input logic [15:0] payload_start_o,
  input logic [15:0] payload_length_o
);

  // hold a result until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped before transfer");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= rhp_pkg::ST_PADDING)
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != rhp_pkg::ST_OK |->
      !marker_o && rtp_pt_o == '0 && seq_num_o == '0 &&
      media_timestamp_o == '0 && source_id_o == '0 &&
      payload_start_o == '0 && payload_length_o == '0)
    else $error("error descriptor carries header fields");

  // payload offset is the fixed header plus whole 32-bit words
  a_offset_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rhp_pkg::ST_OK |->
      payload_start_o >= 16'(rhp_pkg::FIXED_HDR) && payload_start_o[1:0] == 2'b00)
    else $error("payload offset misaligned");

endmodule

bind rtp_header_parser_unit rhp_checker u_rhp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .marker_o         (marker_o),
  .rtp_pt_o         (rtp_pt_o),
  .seq_num_o        (seq_num_o),
  .media_timestamp_o(media_timestamp_o),
  .source_id_o      (source_id_o),
  .payload_start_o  (payload_start_o),
  .payload_length_o (payload_length_o)
);

### tb/tb_rtp_header_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for rtp_header_parser_unit: streams RTP datagrams byte by byte and
// checks every descriptor against a behavioural parser kept in step with accepted bytes.
// Depends on rhp_pkg and the RTL of the block; reads no files.
module tb_rtp_header_parser_unit;

  localparam int unsigned MAX_BYTES     = rhp_pkg::MAX_DATAGRAM_BYTES_DEF;
  localparam int unsigned WORD_BYTES    = 4;    // size of one CSRC entry or extension word
  localparam int unsigned PAD_BIT       = 5;    // header byte 0 flags
  localparam int unsigned EXT_BIT       = 4;
  localparam int unsigned EXT_BUILD_MAX = 64;   // longer extensions are left unfilled
  localparam int unsigned ITEM_TARGET   = 700;
  localparam int unsigned MIN_FRAMES    = 24;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned CYCLE_LIMIT   = 8000000;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_e;

  // Recipe for one datagram; cut_len of zero keeps the whole datagram.
  typedef struct packed {
    logic [1:0]           ver;
    logic                 pad_f;
    logic                 ext_f;
    logic [3:0]           cc;
    logic [15:0]          ext_words;
    logic [16:0]          pay_len;
    logic [7:0]           pad_n;
    logic [16:0]          cut_len;
    logic                 ovr_en;
    logic [7:0]           ovr;
    fill_e                fill;
    logic                 typed;
    rhp_pkg::rhp_status_e want;
  } frame_plan_t;

  typedef struct packed {
    rhp_pkg::rhp_status_e status;
    logic                 marker;
    logic [6:0]           ptype;
    logic [15:0]          seq;
    logic [31:0]          stamp;
    logic [31:0]          source;
    logic [15:0]          start;
    logic [15:0]          length;
    logic [31:0]          arrival;
    logic                 typed;
    rhp_pkg::rhp_status_e want;
  } rtp_desc_t;

  // Directed datagrams: error codes and the ok status are written in by hand,
  // all other descriptor fields come from the parser model.
  localparam frame_plan_t DIRECTED_PLAN [19] = '{
    '{2'd2, 1'b0, 1'b0, 4'd0,  16'd0, 17'd0,  8'd0,  17'd1,  1'b0, 8'd0,
      FILL_RAND, 1'b1, rhp_pkg::ST_SHORT},
    '{2'd2, 1'b0, 1'b0, 4'd0,  16'd0, 17'd4,  8'd0,  17'd11, 1'b0, 8'd0,
      FILL_ONES, 1'b1, rhp_pkg::ST_SHORT},
    '{2'd0, 1'b0, 1'b0, 4'd0,  16'd0, 17'd3,  8'd0,  17'd0,  1'b0, 8'd0,
      FILL_RAND, 1'b1, rhp_pkg::ST_VERSION},
    '{2'd1, 1'b1, 1'b1, 4'd15, 16'd0, 17'd0,  8'd1,  17'd12, 1'b0, 8'd0,
      FILL_ONES, 1'b1, rhp_pkg::ST_VERSION},
    '{2'd3, 1'b0, 1'b0, 4'd0,  16'd0, 17'd2,  8'd0,  17'd0,  1'b0, 8'd0,
      FILL_RAND, 1'b1, rhp_pkg::ST_VERSION},
    '{2'd2, 1'b0, 1'b0, 4'd15, 16'd0, 17'd0,  8'd0,  17'd71, 1'b0, 8'd0,
      FILL_RAND, 1'b1, rhp_pkg::ST_CSRC},
    '{2'd2, 1'b0, 1'b1, 4'd2,  16'd0, 17'd0,  8'd0,  17'd23, 1'b0, 8'd0,
      FILL_RAND, 1'b1, rhp_pkg::ST_EXT_HDR},
    '{2'd2, 1'b0, 1'b1, 4'd0,  16'd3, 17'd0,  8'd0,  17'd27, 1'b0, 8'd0,
      FILL_RAND, 1'b1, rhp_pkg::ST_EXT_DATA},
    '{2'd2, 1'b1, 1'b0, 4'd0,  16'd0, 17'd4,  8'd2,  17'd0,  1'b1, 8'd0,
      FILL_RAND, 1'b1, rhp_pkg::ST_PADDING},
    '{2'd2, 1'b1, 1'b0, 4'd0,  16'd0, 17'd2,  8'd1,  17'd0,  1'b1, 8'd200,
      FILL_RAND, 1'b1, rhp_pkg::ST_PADDING},
    '{2'd2, 1'b1, 1'b1, 4'd1,  16'd1, 17'd0,  8'd3,  17'd0,  1'b1, 8'd255,
      FILL_RAND, 1'b1, rhp_pkg::ST_PADDING},
    '{2'd2, 1'b0, 1'b0, 4'd0,  16'd0, 17'd0,  8'd0,  17'd0,  1'b0, 8'd0,
      FILL_ZERO, 1'b1, rhp_pkg::ST_OK},
    '{2'd2, 1'b0, 1'b0, 4'd0,  16'd0, 17'd1,  8'd0,  17'd0,  1'b0, 8'd0,
      FILL_ONES, 1'b1, rhp_pkg::ST_OK},
    '{2'd2, 1'b1, 1'b1, 4'd15, 16'd2, 17'd5,  8'd3,  17'd0,  1'b0, 8'd0,
      FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{2'd2, 1'b1, 1'b0, 4'd0,  16'd0, 17'd0,  8'd4,  17'd0,  1'b0, 8'd0,
      FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{2'd2, 1'b0, 1'b1, 4'd3,  16'd0, 17'd6,  8'd0,  17'd0,  1'b0, 8'd0,
      FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{2'd2, 1'b1, 1'b0, 4'd0,  16'd0, 17'd10, 8'd20, 17'd0,  1'b0, 8'd0,
      FILL_ONES, 1'b0, rhp_pkg::ST_OK},
    '{2'd2, 1'b1, 1'b0, 4'd0,  16'd0, 17'd0,  8'd7,  17'd0,  1'b0, 8'd0,
      FILL_RAND, 1'b0, rhp_pkg::ST_OK},
    '{2'd2, 1'b0, 1'b0, 4'd0,  16'd0, 17'd2,  8'd0,  17'd0,  1'b0, 8'd0,
      FILL_RAND, 1'b1, rhp_pkg::ST_OK}
  };

  // Clock, reset and block inputs, all known from time zero.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [7:0]  data_byte_i    = 8'd0;
  logic        last_byte_i    = 1'b0;
  logic [31:0] arrival_time_i = 32'd0;
  logic        out_ready_i    = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic        marker_o;
  logic [6:0]  rtp_pt_o;
  logic [15:0] seq_num_o;
  logic [31:0] media_timestamp_o;
  logic [31:0] source_id_o;
  logic [15:0] payload_start_o;
  logic [15:0] payload_length_o;
  logic [31:0] arrival_time_out_o;

  // Parser model state, mirroring the capture registers of the block.
  int unsigned byte_count;
  logic [7:0]  hdr0_q;
  logic [7:0]  hdr1_q;
  logic [15:0] seq_q;
  logic [31:0] stamp_q;
  logic [31:0] source_q;
  logic [15:0] ext_words_q;
  logic [31:0] arrival_q;

  rtp_desc_t   pending_descs[$];
  rtp_desc_t   head_desc;
  logic [7:0]  frame[$];
  int unsigned fail_count   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          calm         = 1'b0;

  rtp_header_parser_unit #(
    .MAX_DATAGRAM_BYTES (MAX_BYTES)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .arrival_time_i     (arrival_time_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .marker_o           (marker_o),
    .rtp_pt_o           (rtp_pt_o),
    .seq_num_o          (seq_num_o),
    .media_timestamp_o  (media_timestamp_o),
    .source_id_o        (source_id_o),
    .payload_start_o    (payload_start_o),
    .payload_length_o   (payload_length_o),
    .arrival_time_out_o (arrival_time_out_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle length for either side: mostly none, sometimes a few cycles, rarely a long one.
  // In a calm stretch both sides run flat out.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Advance the parser model by one accepted byte; on the flagged byte queue
  // the descriptor the block must produce.
  task automatic parse_byte(input logic [7:0] b, input logic last, input logic [31:0] arr,
                            input logic typed, input rhp_pkg::rhp_status_e want);
    int unsigned len;
    int unsigned off;
    int unsigned pad;
    int unsigned csrc;
    int unsigned ext_at;
    rhp_pkg::rhp_status_e st;
    rtp_desc_t   d;
    if (byte_count == 0) arrival_q = arr;
    if (byte_count < MAX_BYTES) begin
      ext_at = 32'(rhp_pkg::FIXED_HDR) + WORD_BYTES * 32'(hdr0_q[3:0]);
      if (byte_count == 0) hdr0_q = b;
      else if (byte_count == 1) hdr1_q = b;
      else if (byte_count < 4) seq_q = {seq_q[7:0], b};
      else if (byte_count < 8) stamp_q = {stamp_q[23:0], b};
      else if (byte_count < 12) source_q = {source_q[23:0], b};
      else if (hdr0_q[EXT_BIT] && (byte_count == ext_at + 2 || byte_count == ext_at + 3))
        ext_words_q = {ext_words_q[7:0], b};
      byte_count++;
    end
    if (!last) return;

    len = byte_count;
    off = 32'(rhp_pkg::FIXED_HDR);
    pad = 0;
    st  = rhp_pkg::ST_OK;
    if (len < 32'(rhp_pkg::FIXED_HDR)) begin
      st = rhp_pkg::ST_SHORT;
    end else if (hdr0_q[7:6] != rhp_pkg::RTP_VERSION) begin
      st = rhp_pkg::ST_VERSION;
    end else begin
      csrc = WORD_BYTES * 32'(hdr0_q[3:0]);
      if (len - off < csrc) begin
        st = rhp_pkg::ST_CSRC;
      end else begin
        off += csrc;
        if (hdr0_q[EXT_BIT]) begin
          if (len - off < 32'(rhp_pkg::EXT_HDR)) begin
            st = rhp_pkg::ST_EXT_HDR;
          end else begin
            off += 32'(rhp_pkg::EXT_HDR);
            if (len - off < WORD_BYTES * 32'(ext_words_q)) st = rhp_pkg::ST_EXT_DATA;
            else off += WORD_BYTES * 32'(ext_words_q);
          end
        end
        // the flagged byte itself carries the pad count
        if (st == rhp_pkg::ST_OK && hdr0_q[PAD_BIT]) begin
          pad = 32'(b);
          if (pad == 0 || pad > len - off) st = rhp_pkg::ST_PADDING;
        end
      end
    end

    d         = '0;
    d.status  = st;
    d.arrival = arrival_q;
    d.typed   = typed;
    d.want    = want;
    if (st == rhp_pkg::ST_OK) begin
      d.marker = hdr1_q[7];
      d.ptype  = hdr1_q[6:0];
      d.seq    = seq_q;
      d.stamp  = stamp_q;
      d.source = source_q;
      d.start  = off[15:0];
      d.length = 16'(len - off - pad);
    end
    pending_descs.push_back(d);
    byte_count  = 0;
    ext_words_q = '0;
  endtask

  // Fill the frame queue from a recipe, then cut it and patch its last byte as asked.
  task automatic build_frame(input frame_plan_t p);
    logic [87:0] fixed;
    frame.delete();
    case (p.fill)
      FILL_ZERO: fixed = '0;
      FILL_ONES: fixed = '1;
      default:   fixed = 88'({$urandom(), $urandom(), $urandom()});
    endcase
    frame.push_back({p.ver, p.pad_f, p.ext_f, p.cc});
    for (int i = 10; i >= 0; i--) frame.push_back(fixed[i*8 +: 8]);
    repeat (WORD_BYTES * p.cc) frame.push_back(8'($urandom()));
    if (p.ext_f) begin
      frame.push_back(8'($urandom()));
      frame.push_back(8'($urandom()));
      frame.push_back(p.ext_words[15:8]);
      frame.push_back(p.ext_words[7:0]);
      // drop the data of huge extensions: the datagram simply ends short of it
      if (p.ext_words <= EXT_BUILD_MAX)
        repeat (WORD_BYTES * p.ext_words) frame.push_back(8'($urandom()));
    end
    repeat (p.pay_len) frame.push_back(8'($urandom()));
    if (p.pad_f && p.pad_n != 0) begin
      repeat (p.pad_n - 1) frame.push_back(8'($urandom()));
      frame.push_back(p.pad_n);
    end
    if (p.cut_len != 0)
      while (frame.size() > p.cut_len) void'(frame.pop_back());
    if (p.ovr_en) frame[frame.size() - 1] = p.ovr;
  endtask

  // Offer one byte, hold it until the transfer completes, then feed the model.
  // Called and returns at a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input rhp_pkg::rhp_status_e want);
    int unsigned gap;
    logic [31:0] arr;
    gap = pick_gap();
    arr = $urandom();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    last_byte_i    <= last;
    arrival_time_i <= arr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    parse_byte(b, last, arr, typed, want);
  endtask

  task automatic send_frame(input logic typed, input rhp_pkg::rhp_status_e want);
    for (int i = 0; i < frame.size(); i++)
      send_byte(frame[i], i == frame.size() - 1, typed, want);
    frames_sent++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Result side: check each transfer against the oldest descriptor, then
  // decide whether to stall the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_descs.size() == 0) begin
        $display("%0t: unexpected descriptor, expected none, got status %0d",
                 $time, status_o);
        fail_count++;
      end else begin
        head_desc = pending_descs.pop_front();
        compare_field("status", head_desc.status, status_o);
        if (head_desc.typed) compare_field("status (directed)", head_desc.want, status_o);
        compare_field("marker", head_desc.marker, marker_o);
        compare_field("rtp_pt", head_desc.ptype, rtp_pt_o);
        compare_field("seq_num", head_desc.seq, seq_num_o);
        compare_field("media_timestamp", head_desc.stamp, media_timestamp_o);
        compare_field("source_id", head_desc.source, source_id_o);
        compare_field("payload_start", head_desc.start, payload_start_o);
        compare_field("payload_length", head_desc.length, payload_length_o);
        compare_field("arrival_time_out", head_desc.arrival, arrival_time_out_o);
      end
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    frame_plan_t plan;
    int unsigned kind;
    byte_count  = 0;
    hdr0_q      = '0;
    hdr1_q      = '0;
    seq_q       = '0;
    stamp_q     = '0;
    source_q    = '0;
    ext_words_q = '0;
    arrival_q   = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed datagrams: every status and field extremes.
    foreach (DIRECTED_PLAN[i]) begin
      build_frame(DIRECTED_PLAN[i]);
      send_frame(DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
    end

    // Random datagrams: mostly well formed, the rest broken or plain noise.
    while (bytes_sent < ITEM_TARGET || frames_sent < MIN_FRAMES) begin
      if ($urandom_range(0, 7) == 0) calm = ($urandom_range(0, 3) == 0);
      plan           = '0;
      plan.ver       = rhp_pkg::RTP_VERSION;
      plan.pad_f     = 1'($urandom_range(0, 1));
      plan.ext_f     = 1'($urandom_range(0, 1));
      plan.cc        = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                                     4'($urandom_range(0, 2));
      plan.ext_words = 16'($urandom_range(0, 4));
      plan.pay_len   = 17'($urandom_range(0, 24));
      plan.pad_n     = 8'($urandom_range(1, 8));
      plan.fill      = FILL_RAND;
      kind = $urandom_range(0, 99);
      if (kind >= 75) begin
        case ($urandom_range(0, 3))
          0: plan.ver = 2'($urandom_range(0, 3));
          1: plan.cut_len = 17'($urandom_range(1, 40));
          2: begin
            plan.ovr_en = 1'b1;
            plan.ovr    = 8'($urandom());
          end
          default: plan.ext_words = 16'($urandom_range(0, 65535));
        endcase
      end
      build_frame(plan);
      // noise: a short run of arbitrary bytes
      if (kind >= 95) begin
        frame.delete();
        repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom()));
      end
      send_frame(1'b0, rhp_pkg::ST_OK);
    end
    in_valid_i <= 1'b0;

    while (pending_descs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
